// ----- hdl/lfpid_pkg.sv -----
// Package for the line-follower PID steering core.
// Holds sensor weights, drive limits, register indexes and the steering select type.
// No dependencies; imported by line_follow_pid_steering_core.
package lfpid_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SENSE_USED   = (SENSOR_COUNT > 8) ? 8 : SENSOR_COUNT;
  localparam logic [7:0] SENSE_MASK =
    (SENSOR_COUNT >= 8) ? 8'hFF : 8'((1 << SENSOR_COUNT) - 1);

  // per-sensor error weight, sensor 0 first
  localparam logic signed [6:0] WEIGHT [8] = '{
    7'sd25, 7'sd20, 7'sd12, 7'sd5, -7'sd5, -7'sd12, -7'sd20, -7'sd25
  };

  localparam logic signed [9:0] DRIVE_MIN = -10'sd20;
  localparam logic signed [9:0] DRIVE_MAX = 10'sd70;
  localparam logic [13:0] INT_SCALE = 14'd100;

  // PID sum / (256 * 200) = (sum >> 11) / 25
  localparam int          DIV_SHIFT  = 11;
  localparam logic [34:0] SAT_LIMIT  = 35'd13107200; // 256 * 200 * 256
  localparam logic [15:0] RECIP_25   = 16'd41944;    // ceil(2^20 / 25)
  localparam int          RECIP_BITS = 20;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_BASE      = 3'd3;
  localparam logic [2:0] REG_LEFT_MASK = 3'd4;
  localparam logic [2:0] REG_RIGHT_MASK = 3'd5;
  localparam logic [2:0] REG_LOST_SLOW = 3'd6;
  localparam logic [2:0] REG_LOST_FAST = 3'd7;

  typedef enum logic [1:0] {
    STEER_PID,    // line seen: PID drives
    STEER_LEFT,   // lost, last seen on the left: A slow, B fast
    STEER_RIGHT,  // lost, last seen on the right: A fast, B slow
    STEER_HOLD    // lost, no side matched: repeat last drives
  } steer_t;

  function automatic logic signed [7:0] sat_drive(input logic signed [9:0] v);
    if (v < DRIVE_MIN) begin
      return 8'(DRIVE_MIN);
    end else if (v > DRIVE_MAX) begin
      return 8'(DRIVE_MAX);
    end else begin
      return 8'(v);
    end
  endfunction

endpackage

// ----- hdl/line_follow_pid_steering_core.sv -----
// Line-follower PID steering core: sensor reading in, two wheel drives out.
// Five-register pipeline: input, error/integral, products, magnitude, result.
// Depends on lfpid_pkg.
//
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-----------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata[7:0] sensor_bits
// m_       | out | m_tvalid/m_tready  | m_tdata drive_a, drive_b; m_tuser line_lost
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One reading is taken every cycle while the pipeline advances; each passes the input,
// error/integral, products, magnitude and result registers. The whole pipeline advances
// together and stops only when the result register is full and m_tready is low; s_tready
// follows that. Error, integral and last-seen state update in the second stage, only for
// readings that see the line, so each reading sees the state left by the last that did.
// rst (synchronous) clears state and sets the configuration registers to their defaults.
module line_follow_pid_steering_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sensor_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] drive_a, [15:8] drive_b
  output logic        m_tuser,   // [0] line_lost
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import lfpid_pkg::*;

  // configuration registers
  logic [17:0]       gain_p, gain_i, gain_d;
  logic [6:0]        base_speed;
  logic [7:0]        left_mask, right_mask;
  logic signed [7:0] lost_slow_drive, lost_fast_drive;

  // controller state
  logic [7:0]         last_seen_bits;
  logic signed [6:0]  prev_error;
  logic signed [14:0] error_integral;
  logic signed [7:0]  held_drive_a, held_drive_b;

  // pipeline
  logic               adv;
  logic               valid1, valid2, valid3, valid4;
  logic [7:0]         bits1;
  logic signed [6:0]  err2;
  logic signed [7:0]  diff2;
  logic signed [14:0] int2;
  steer_t             steer2, steer3, steer4;
  logic signed [25:0] prod_p;
  logic signed [33:0] prod_i;
  logic signed [26:0] prod_d;
  logic               neg4, big4;
  logic [12:0]        quot_in4;

  // stage 1 combinational
  logic               seen;
  logic signed [6:0]  err;
  logic signed [7:0]  diff;
  logic [13:0]        int_limit;
  logic               int_open;
  logic signed [15:0] int_sum;
  logic signed [14:0] error_integral_next;
  steer_t             steer;

  // stage 3 combinational
  logic signed [34:0] pid_sum;
  logic [34:0]        pid_mag;

  // output stage combinational
  logic [28:0]        quot_prod;
  logic [7:0]         term_mag;
  logic signed [9:0]  term;
  logic signed [9:0]  raw_a, raw_b;
  logic signed [7:0]  slow_sat, fast_sat;
  logic signed [7:0]  drive_a_next, drive_b_next;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= '0;
      gain_i          <= '0;
      gain_d          <= '0;
      base_speed      <= '0;
      left_mask       <= 8'd240;
      right_mask      <= 8'd15;
      lost_slow_drive <= -8'sd20;
      lost_fast_drive <= 8'sd60;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:     gain_p          <= cfg_data;
        REG_GAIN_I:     gain_i          <= cfg_data;
        REG_GAIN_D:     gain_d          <= cfg_data;
        REG_BASE:       base_speed      <= cfg_data[6:0];
        REG_LEFT_MASK:  left_mask       <= cfg_data[7:0];
        REG_RIGHT_MASK: right_mask      <= cfg_data[7:0];
        REG_LOST_SLOW:  lost_slow_drive <= $signed(cfg_data[7:0]);
        REG_LOST_FAST:  lost_fast_drive <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // stage 1: error, derivative, bounded integral, lost-line steering choice
  always_comb begin
    seen = |bits1;
    err  = '0;
    for (int k = 0; k < SENSE_USED; k++) begin
      if (bits1[k]) begin
        err = err + WEIGHT[k];
      end
    end
    diff      = 8'(err) - 8'(prev_error);
    int_limit = 14'(base_speed * INT_SCALE);
    int_open  = (16'(error_integral) < $signed({2'b00, int_limit})) &&
                (16'(error_integral) > -$signed({2'b00, int_limit}));
    int_sum   = 16'(error_integral) + 16'(err);
    error_integral_next = int_open ? 15'(int_sum) : error_integral;

    if (seen) begin
      steer = STEER_PID;
    end else if (|(last_seen_bits & left_mask)) begin
      steer = STEER_LEFT;
    end else if (|(last_seen_bits & right_mask)) begin
      steer = STEER_RIGHT;
    end else begin
      steer = STEER_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
      last_seen_bits <= '0;
      prev_error     <= '0;
      error_integral <= '0;
    end else if (adv) begin
      valid1 <= s_tvalid;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
      if (valid1 && seen) begin
        last_seen_bits <= bits1;
        prev_error     <= err;
        error_integral <= error_integral_next;
      end
    end
  end

  // stage 3: magnitude of the PID sum, split for the divide by 51200
  always_comb begin
    pid_sum = 35'(prod_p) + 35'(prod_i) + 35'(prod_d);
    pid_mag = pid_sum[34] ? 35'(-pid_sum) : 35'(pid_sum);
  end

  // payload registers of stages 1 to 4
  always_ff @(posedge clk) begin
    if (adv) begin
      bits1  <= s_tdata & SENSE_MASK;
      err2   <= err;
      diff2  <= diff;
      int2   <= error_integral_next;
      steer2 <= steer;
      prod_p <= $signed({1'b0, gain_p}) * err2;
      prod_i <= $signed({1'b0, gain_i}) * int2;
      prod_d <= $signed({1'b0, gain_d}) * diff2;
      steer3 <= steer2;
      neg4     <= pid_sum[34];
      big4     <= pid_mag >= SAT_LIMIT;
      quot_in4 <= pid_mag[DIV_SHIFT +: 13];
      steer4   <= steer3;
    end
  end

  // output stage: divide by 25 via reciprocal, add to base, saturate, or pick lost-line drives
  always_comb begin
    quot_prod = 29'(quot_in4) * 29'(RECIP_25);
    term_mag  = big4 ? 8'hFF : quot_prod[RECIP_BITS +: 8];
    term      = neg4 ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});
    raw_a     = $signed({3'b000, base_speed}) + term;
    raw_b     = $signed({3'b000, base_speed}) - term;
    slow_sat  = sat_drive(10'(lost_slow_drive));
    fast_sat  = sat_drive(10'(lost_fast_drive));
    unique case (steer4)
      STEER_PID: begin
        drive_a_next = sat_drive(raw_a);
        drive_b_next = sat_drive(raw_b);
      end
      STEER_LEFT: begin
        drive_a_next = slow_sat;
        drive_b_next = fast_sat;
      end
      STEER_RIGHT: begin
        drive_a_next = fast_sat;
        drive_b_next = slow_sat;
      end
      default: begin
        drive_a_next = held_drive_a;
        drive_b_next = held_drive_b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      held_drive_a <= '0;
      held_drive_b <= '0;
    end else if (adv) begin
      m_tvalid <= valid4;
      if (valid4) begin
        held_drive_a <= drive_a_next;
        held_drive_b <= drive_b_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid4) begin
      m_tdata <= {drive_b_next, drive_a_next};
      m_tuser <= (steer4 != STEER_PID);
    end
  end

endmodule
